// ----- rtl/pma_pkg.sv -----
package pma_pkg;

  // Geometry of the page map.
  localparam int VIRT_PAGES  = 8192;
  localparam int PHYS_PAGES  = 4096;
  localparam int PAGE_SHIFT  = 12;
  localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;

  localparam int ADDR_W      = 25;               // virtual address and byte counts
  localparam int PHYS_ADDR_W = 24;               // translated address
  localparam int VPN_W       = $clog2(VIRT_PAGES);
  localparam int PPN_W       = $clog2(PHYS_PAGES);
  localparam int CNT_W       = PPN_W + 1;        // page count register, region end
  localparam int PGS_W       = ADDR_W - PAGE_SHIFT + 1;  // pages in one request
  localparam int FWD_W       = PPN_W + 1;        // dirty bit plus page number
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = CNT_W;

  // Request modes.
  localparam logic [2:0] MODE_ALLOC     = 3'd0;
  localparam logic [2:0] MODE_TRANSLATE = 3'd1;
  localparam logic [2:0] MODE_EXISTS    = 3'd2;
  localparam logic [2:0] MODE_SET_DIRTY = 3'd3;
  localparam logic [2:0] MODE_GET_DIRTY = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_COUNT = 1'd1;

  localparam logic [PPN_W-1:0] STORE_BASE_RST  = PPN_W'(1);
  localparam logic [CNT_W-1:0] STORE_COUNT_RST = CNT_W'(4095);

  typedef struct packed {
    logic [2:0]        mode;
    logic [ADDR_W-1:0] virt_addr;
    logic [ADDR_W-1:0] alloc_bytes;
  } req_word_t;

  typedef struct packed {
    logic                   flag;
    logic [PHYS_ADDR_W-1:0] phys_addr;
    logic                   unmapped_error;
  } rsp_word_t;

  typedef struct packed {
    logic             dirty;
    logic [PPN_W-1:0] ppn;
  } fwd_entry_t;

endpackage

// ----- rtl/pma_ram.sv -----
module pma_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/page_map_allocator_unit.sv -----
// Page map allocator. Maps 4 KiB virtual pages onto physical pages of a backing
// store region with a forward table (virtual page to physical page and dirty
// bit, 8192 entries) and a reverse table (one in-use bit per physical page,
// 4096 entries), both held in simple dual-port synchronous RAMs. After reset the
// block sweeps both tables to zero, one entry per cycle; request stall stays
// high during the sweep, while configuration writes are taken at any time.
// Every request word returns exactly one response word. Translate, exists,
// set dirty and read dirty make one forward table read and, for set dirty, a
// write back in the lookup state once the output register is free. Alloc goes
// from the accepting cycle to a set-up state for the capacity check, then, if
// that passes, through a read state and a check state for every reverse table
// probe (issue the read, test the entry and claim it), then to a result state
// that posts the result; the next-fit search adds probes when it passes over
// used pages, and a fruitless search ends after a full pass over the region.
// The probe loop through the reverse RAM sets the cost of an alloc. One
// request is worked on at a time, but a new request word is accepted while the
// last response word still waits in the output register.
module page_map_allocator_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [pma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pma_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  pma_pkg::req_word_t         req_word,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output pma_pkg::rsp_word_t         rsp_word
);

  import pma_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_LOOKUP    = 7'b0000100,
    S_SETUP     = 7'b0001000,
    S_PROBE_RD  = 7'b0010000,
    S_PROBE_CHK = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [PPN_W-1:0] store_base;
  logic [CNT_W-1:0] store_count;

  // Allocator state.
  logic [PPN_W-1:0]  sp;
  logic [ADDR_W-1:0] alloc_bytes;

  // Working registers of the current request.
  req_word_t        req_r;
  logic [VPN_W-1:0] clr_cnt;
  logic [VPN_W-1:0] vpage_cur;
  logic [CNT_W-1:0] end_r;
  logic [CNT_W-1:0] span_r;
  logic [CNT_W-1:0] probe_cnt;
  logic [PGS_W-1:0] pages_left;
  logic             res_flag;

  // RAM ports.
  logic             fwd_we, fwd_re;
  logic [VPN_W-1:0] fwd_waddr, fwd_raddr;
  fwd_entry_t       fwd_wdata, fwd_rdata;
  logic             rev_we, rev_re;
  logic [PPN_W-1:0] rev_waddr, rev_raddr;
  logic             rev_wdata, rev_rdata;

  logic req_fire, rsp_free;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  // The output register can take a new word when empty or being drained.
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Virtual page of a byte address.
  function automatic logic [VPN_W-1:0] vpage_of(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] shifted;
    shifted  = addr >> PAGE_SHIFT;
    vpage_of = shifted[VPN_W-1:0];
  endfunction

  // Set-up arithmetic for alloc: region end, span and capacity check.
  logic [PPN_W+1:0]          region_sum;
  logic [CNT_W-1:0]          region_end;
  logic [CNT_W-1:0]          region_span;
  logic [ADDR_W:0]           bytes_total;
  logic [CNT_W+PAGE_SHIFT-1:0] capacity;
  logic                      cap_ok;
  logic [ADDR_W:0]           size_up;
  logic [PGS_W-1:0]          req_pages;

  always_comb begin
    region_sum  = {2'b00, store_base} + {1'b0, store_count};
    region_end  = (region_sum > (PPN_W+2)'(PHYS_PAGES)) ? CNT_W'(PHYS_PAGES)
                                                        : region_sum[CNT_W-1:0];
    region_span = (region_end > {1'b0, store_base}) ? region_end - {1'b0, store_base}
                                                    : '0;
    capacity    = {store_count, {PAGE_SHIFT{1'b0}}};
    bytes_total = {1'b0, alloc_bytes} + {1'b0, req_r.alloc_bytes};
    cap_ok      = ((ADDR_W+1)'(capacity) >= bytes_total);
    size_up     = {1'b0, req_r.alloc_bytes} + (ADDR_W+1)'(PAGE_BYTES - 1);
    req_pages   = size_up[ADDR_W:PAGE_SHIFT];
  end

  // Next-fit step: advance and wrap to the base at the region end.
  logic [PPN_W:0]   sp_inc;
  logic [PPN_W-1:0] sp_step;

  assign sp_inc  = {1'b0, sp} + (PPN_W+1)'(1);
  assign sp_step = (sp_inc >= end_r) ? store_base : sp_inc[PPN_W-1:0];

  // A claimed reverse entry is set unless the virtual address is zero, which reads free.
  logic claim_used;
  assign claim_used = (req_r.virt_addr[PAGE_SHIFT-1:0] != '0) || (vpage_cur != '0);

  logic lookup_done;
  assign lookup_done = (state == S_LOOKUP) && rsp_free;

  // RAM control.
  always_comb begin
    fwd_we    = 1'b0;
    fwd_waddr = vpage_cur;
    fwd_wdata = '0;
    fwd_re    = req_fire;
    fwd_raddr = vpage_of(req_word.virt_addr);
    rev_we    = 1'b0;
    rev_waddr = sp;
    rev_wdata = 1'b0;
    rev_re    = (state == S_PROBE_RD);
    rev_raddr = sp_step;
    priority if (state == S_CLEAR) begin
      fwd_we    = 1'b1;
      fwd_waddr = clr_cnt;
      rev_we    = 1'b1;
      rev_waddr = clr_cnt[PPN_W-1:0];
    end else if (state == S_PROBE_CHK && !rev_rdata) begin
      fwd_we          = 1'b1;
      fwd_wdata.dirty = 1'b0;
      fwd_wdata.ppn   = sp;
      rev_we          = 1'b1;
      rev_wdata       = claim_used;
    end else if (lookup_done && req_r.mode == MODE_SET_DIRTY) begin
      fwd_we          = 1'b1;
      fwd_wdata.dirty = 1'b1;
      fwd_wdata.ppn   = fwd_rdata.ppn;
    end else begin
      // No table write in this cycle.
      fwd_we = 1'b0;
    end
  end

  pma_ram #(
    .ADDR_W (VPN_W),
    .DATA_W (FWD_W)
  ) u_fwd_ram (
    .clk   (clk),
    .we    (fwd_we),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .re    (fwd_re),
    .raddr (fwd_raddr),
    .rdata (fwd_rdata)
  );

  pma_ram #(
    .ADDR_W (PPN_W),
    .DATA_W (1)
  ) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .waddr (rev_waddr),
    .wdata (rev_wdata),
    .re    (rev_re),
    .raddr (rev_raddr),
    .rdata (rev_rdata)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) state_next = (req_word.mode == MODE_ALLOC) ? S_SETUP : S_LOOKUP;
      end
      S_LOOKUP: begin
        if (rsp_free) state_next = S_IDLE;
      end
      S_SETUP: begin
        state_next = (cap_ok && req_pages != '0) ? S_PROBE_RD : S_RESULT;
      end
      S_PROBE_RD: begin
        state_next = (probe_cnt == span_r) ? S_RESULT : S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        state_next = (!rev_rdata && pages_left == PGS_W'(1)) ? S_RESULT : S_PROBE_RD;
      end
      S_RESULT: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      sp          <= '0;
      alloc_bytes <= '0;
      store_base  <= STORE_BASE_RST;
      store_count <= STORE_COUNT_RST;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + VPN_W'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STORE_BASE:  store_base  <= cfg_data[PPN_W-1:0];
          CFG_STORE_COUNT: store_count <= cfg_data;
          default: ;
        endcase
      end
      // The pointer is raised to the base even when the request is rejected.
      if (state == S_SETUP && sp < store_base) begin
        sp <= store_base;
      end
      if (state == S_PROBE_RD && probe_cnt != span_r) begin
        sp <= sp_step;
      end
      if (state == S_PROBE_CHK && !rev_rdata) begin
        alloc_bytes <= alloc_bytes + ADDR_W'(PAGE_BYTES);
      end
    end
  end

  // Working registers need no reset.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_r     <= req_word;
      vpage_cur <= vpage_of(req_word.virt_addr);
    end
    unique case (state)
      S_SETUP: begin
        end_r      <= region_end;
        span_r     <= region_span;
        probe_cnt  <= '0;
        pages_left <= req_pages;
        res_flag   <= cap_ok;
      end
      S_PROBE_RD: begin
        if (probe_cnt == span_r) begin
          res_flag <= 1'b0;
        end else begin
          probe_cnt <= probe_cnt + CNT_W'(1);
        end
      end
      S_PROBE_CHK: begin
        if (!rev_rdata) begin
          probe_cnt  <= '0;
          pages_left <= pages_left - PGS_W'(1);
          vpage_cur  <= vpage_cur + VPN_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Response word from a table lookup.
  rsp_word_t lookup_rsp;
  logic [PPN_W+PAGE_SHIFT-1:0] phys_full;

  always_comb begin
    lookup_rsp = '0;
    phys_full  = {fwd_rdata.ppn, {PAGE_SHIFT{1'b0}}};
    unique case (req_r.mode)
      MODE_TRANSLATE: begin
        if (fwd_rdata.ppn != '0) begin
          lookup_rsp.phys_addr = PHYS_ADDR_W'(phys_full);
        end else begin
          lookup_rsp.unmapped_error = 1'b1;
        end
      end
      MODE_EXISTS:    lookup_rsp.flag = (fwd_rdata.ppn != '0);
      MODE_GET_DIRTY: lookup_rsp.flag = fwd_rdata.dirty;
      default: ;
    endcase
  end

  // Output register.
  logic rsp_load;
  assign rsp_load = lookup_done || (state == S_RESULT && rsp_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_done) begin
      rsp_word <= lookup_rsp;
    end else if (state == S_RESULT && rsp_free) begin
      rsp_word.flag           <= res_flag;
      rsp_word.phys_addr      <= '0;
      rsp_word.unmapped_error <= 1'b0;
    end
  end

  // While a probe result is tested, the pointer lies inside the store region.
  a_sp_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CHK) |-> (sp >= store_base && {1'b0, sp} < end_r))
    else $error("search pointer outside the store region");

  // Each tested probe has been counted and stays within one pass.
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CHK) |-> (probe_cnt != '0 && probe_cnt <= span_r))
    else $error("probe count out of range");

  // The probe loop only runs while pages remain to be claimed.
  a_pages_left: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_RD || state == S_PROBE_CHK) |-> (pages_left != '0))
    else $error("probe loop running with no pages left");

  // Claiming the last page moves to the result state, with the success flag set, in the cycle after.
  a_claim_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE_CHK && !rev_rdata && pages_left == PGS_W'(1))
      |=> (state == S_RESULT && res_flag))
    else $error("completed allocation did not report success");

endmodule
